>>> src/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg: shared types and constants of the decimating FIR filter
// Holds the coefficient table, the widths of the data path and the state
// encoding of the sequencer.
// ----------------------------------------------------------------------------
package fdf_pkg;

  localparam int TAP_COUNT = 87;
  localparam int TAP_AW    = $clog2(TAP_COUNT);
  localparam int DL_DEPTH  = TAP_COUNT - 1;
  localparam int DL_AW     = $clog2(DL_DEPTH);
  localparam int FILL_W    = $clog2(DL_DEPTH + 1);
  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 14;
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int ACC_W     = 36;
  localparam int PHASE_W   = 3;

  typedef logic signed [TAP_W-1:0] tap_t;

  localparam tap_t TAPS [TAP_COUNT] = '{
    -14'sd5,    -14'sd11,   -14'sd22,   -14'sd36,   -14'sd52,
    -14'sd65,   -14'sd72,   -14'sd67,   -14'sd46,   -14'sd8,
    14'sd45,    14'sd105,   14'sd163,   14'sd205,   14'sd218,
    14'sd194,   14'sd130,   14'sd34,    -14'sd79,   -14'sd183,
    -14'sd252,  -14'sd264,  -14'sd205,  -14'sd76,   14'sd102,
    14'sd293,   14'sd451,   14'sd529,   14'sd490,   14'sd320,
    14'sd33,    -14'sd324,  -14'sd676,  -14'sd935,  -14'sd1011,
    -14'sd832,  -14'sd366,  14'sd377,   14'sd1333,  14'sd2397,
    14'sd3433,  14'sd4302,  14'sd4880,  14'sd5083,  14'sd4880,
    14'sd4302,  14'sd3433,  14'sd2397,  14'sd1333,  14'sd377,
    -14'sd366,  -14'sd832,  -14'sd1011, -14'sd935,  -14'sd676,
    -14'sd324,  14'sd33,    14'sd320,   14'sd490,   14'sd529,
    14'sd451,   14'sd293,   14'sd102,   -14'sd76,   -14'sd205,
    -14'sd264,  -14'sd252,  -14'sd183,  -14'sd79,   14'sd34,
    14'sd130,   14'sd194,   14'sd218,   14'sd205,   14'sd163,
    14'sd105,   14'sd45,    -14'sd8,    -14'sd46,   -14'sd67,
    -14'sd72,   -14'sd65,   -14'sd52,   -14'sd36,   -14'sd22,
    -14'sd11,   -14'sd5
  };

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

>>> src/fdf_ram.sv
// ----------------------------------------------------------------------------
// fdf_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdf_ram #(
  parameter int Width = 16,
  parameter int Depth = 86
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fir_decimate_by_five.sv
// ----------------------------------------------------------------------------
// fir_decimate_by_five: 87-tap low-pass FIR filter with decimation by five
// Filters a stream of signed 16-bit samples and emits every DECIMATION-th
// filtered value, shifted right by OUTPUT_SHIFT and wrapped to 16 bits.
// ----------------------------------------------------------------------------
// Each input word is one signed sample. The block takes one sample at a time
// and accepts the next only once it is stored: the 86 older samples sit in a
// circular buffer in a single-port-read RAM and are read back one per cycle
// for one multiply-accumulate each, followed by a drain of the read and
// multiply stages and a store of the new sample. The delay line
// starts out as all zeros after reset. An output word appears after every
// DECIMATION-th input word and waits in an output register until taken; the
// next sample is still accepted while it waits. If the following output word
// is ready before that one is taken, the store cycle waits until it is taken.
module fir_decimate_by_five #(
  parameter int DECIMATION   = 5,
  parameter int OUTPUT_SHIFT = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [15:0] filtered_sample
);

  localparam logic [fdf_pkg::PHASE_W-1:0] PhaseLast = fdf_pkg::PHASE_W'(DECIMATION - 1);
  localparam logic [fdf_pkg::DL_AW-1:0]   AddrLast  = fdf_pkg::DL_AW'(fdf_pkg::DL_DEPTH - 1);
  localparam logic [fdf_pkg::FILL_W-1:0]  FillFull  = fdf_pkg::FILL_W'(fdf_pkg::DL_DEPTH);

  fdf_pkg::state_e state_q, state_d;

  logic [fdf_pkg::SAMPLE_W-1:0] x_q, x_d;
  logic [fdf_pkg::DL_AW-1:0]    wp_q, wp_d;
  logic [fdf_pkg::DL_AW-1:0]    rd_q, rd_d;
  logic [fdf_pkg::DL_AW-1:0]    k_q, k_d;
  logic [fdf_pkg::DL_AW-1:0]    k1_q;
  logic [fdf_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic                         v1_q;
  logic                         rv_q;
  logic                         pv_q;
  logic [fdf_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic signed [fdf_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [fdf_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic                         out_valid_q, out_valid_d;
  logic [15:0]                  out_data_q, out_data_d;

  logic                         issue;
  logic                         ram_we;
  logic [fdf_pkg::SAMPLE_W-1:0] ram_rdata;
  logic signed [fdf_pkg::SAMPLE_W-1:0] tap_data;
  logic [fdf_pkg::TAP_AW-1:0]   tap_idx;
  logic signed [fdf_pkg::PROD_W-1:0] prod0;
  logic signed [fdf_pkg::ACC_W-1:0]  acc_shift;
  logic                         emit;
  logic                         slot_free;
  logic                         in_fire;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign issue     = (state_q == fdf_pkg::ST_RUN);
  assign emit      = (phase_q >= PhaseLast);
  assign slot_free = !out_valid_q || m_axis_tready;
  assign tap_idx   = fdf_pkg::TAP_AW'(k1_q) + fdf_pkg::TAP_AW'(1);
  assign tap_data  = v1_q ? $signed(ram_rdata) : '0;
  assign prod0     = $signed(s_axis_tdata) * fdf_pkg::TAPS[0];
  assign acc_shift = acc_q >>> OUTPUT_SHIFT;
  assign ram_we    = (state_q == fdf_pkg::ST_DONE) && (!emit || slot_free);

  fdf_ram #(
    .Width (fdf_pkg::SAMPLE_W),
    .Depth (fdf_pkg::DL_DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (x_q),
    .re_i    (issue),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    wp_d        = wp_q;
    rd_d        = rd_q;
    k_d         = k_q;
    fill_d      = fill_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    prod_d      = tap_data * fdf_pkg::TAPS[tap_idx];

    if (pv_q) begin
      acc_d = acc_q + fdf_pkg::ACC_W'(prod_q);
    end

    case (state_q)
      fdf_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_d     = s_axis_tdata;
          acc_d   = fdf_pkg::ACC_W'(prod0);
          rd_d    = (wp_q == '0) ? AddrLast : wp_q - 1'b1;
          k_d     = '0;
          state_d = fdf_pkg::ST_RUN;
        end
      end
      fdf_pkg::ST_RUN: begin
        rd_d = (rd_q == '0) ? AddrLast : rd_q - 1'b1;
        k_d  = k_q + 1'b1;
        if (k_q == AddrLast) begin
          state_d = fdf_pkg::ST_DRAIN;
        end
      end
      fdf_pkg::ST_DRAIN: begin
        if (!rv_q && !pv_q) begin
          state_d = fdf_pkg::ST_DONE;
        end
      end
      fdf_pkg::ST_DONE: begin
        if (ram_we) begin
          wp_d    = (wp_q == AddrLast) ? '0 : wp_q + 1'b1;
          fill_d  = (fill_q == FillFull) ? fill_q : fill_q + 1'b1;
          phase_d = emit ? '0 : phase_q + 1'b1;
          if (emit) begin
            out_valid_d = 1'b1;
            out_data_d  = acc_shift[15:0];
          end
          state_d = fdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdf_pkg::ST_IDLE;
      wp_q        <= '0;
      rd_q        <= '0;
      k_q         <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rd_q        <= rd_d;
      k_q         <= k_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      rv_q        <= issue;
      pv_q        <= rv_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    k1_q       <= k_q;
    v1_q       <= fdf_pkg::FILL_W'(k_q) < fill_q;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == fdf_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull && wp_q <= AddrLast && rd_q <= AddrLast)
    else $error("delay line pointer or fill count out of range");

  a_write_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!rv_q && !pv_q && !issue))
    else $error("delay line written while a tap read is in flight");

  a_run_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdf_pkg::ST_RUN && k_q == AddrLast) |=> state_q == fdf_pkg::ST_DRAIN)
    else $error("tap sweep did not end after the last delay entry");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending output word lost or changed");
`endif

endmodule

>>> test/fir_decimate_by_five_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_decimate_by_five_check: scoreboard of the decimating FIR filter
// Watches both stream ports, keeps its own delay line and decimation phase,
// forms the expected filtered word for every DECIMATION-th accepted sample and
// compares each output word against the oldest expected one.
// ----------------------------------------------------------------------------
module fir_decimate_by_five_check #(
  parameter int DECIMATION   = 5,
  parameter int OUTPUT_SHIFT = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [fdf_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [fdf_pkg::SAMPLE_W-1:0] m_axis_tdata,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           sample_count_o,
  output int                           word_count_o,
  output int                           wrap_count_o
);

  logic signed [fdf_pkg::SAMPLE_W-1:0] history [fdf_pkg::DL_DEPTH];
  logic [fdf_pkg::PHASE_W-1:0]         phase;
  logic [fdf_pkg::SAMPLE_W-1:0]        filtered_q [$];

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    logic signed [fdf_pkg::ACC_W-1:0]    acc;
    logic signed [fdf_pkg::ACC_W-1:0]    shifted;
    logic signed [fdf_pkg::SAMPLE_W-1:0] newest;
    logic [fdf_pkg::SAMPLE_W-1:0]        want;
    if (!rst_ni) begin
      for (int k = 0; k < fdf_pkg::DL_DEPTH; k++) history[k] = '0;
      phase = '0;
      filtered_q.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
      sample_count_o <= 0;
      word_count_o   <= 0;
      wrap_count_o   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        newest = s_axis_tdata;
        acc = newest * fdf_pkg::TAPS[0];
        for (int k = 0; k < fdf_pkg::DL_DEPTH; k++) begin
          acc = acc + history[k] * fdf_pkg::TAPS[k+1];
        end
        shifted = acc >>> OUTPUT_SHIFT;
        for (int k = fdf_pkg::DL_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = newest;
        if (phase >= DECIMATION - 1) begin
          phase = '0;
          want = shifted[fdf_pkg::SAMPLE_W-1:0];
          filtered_q.push_back(want);
          if (shifted != $signed(want)) wrap_count_o <= wrap_count_o + 1;
        end else begin
          phase = phase + 1'b1;
        end
        sample_count_o <= sample_count_o + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %0d",
                   $time, $signed(m_axis_tdata));
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: filtered_sample mismatch, expected %0d, actual %0d",
                     $time, $signed(want), $signed(m_axis_tdata));
            fail_count_o <= fail_count_o + 1;
          end
        end
        word_count_o <= word_count_o + 1;
      end
      pending_o <= filtered_q.size();
    end
  end

endmodule

>>> test/fir_decimate_by_five_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_decimate_by_five_test: stimulus and verdict for the decimating FIR
// Drives directed extremes, then random noise, small values and full-scale
// bursts matched to the coefficient signs so that the output wraps, with
// random idle cycles on both ports. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module fir_decimate_by_five_test;

  localparam int DECIMATION   = 5;
  localparam int OUTPUT_SHIFT = 15;
  localparam int SAMPLE_TOTAL = 800;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 200;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int fail_count;
  int pending;
  int sample_count;
  int word_count;
  int wrap_count;
  int quiet_cycles = 0;
  int sent         = 0;
  bit steady       = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fir_decimate_by_five #(
    .DECIMATION  (DECIMATION),
    .OUTPUT_SHIFT(OUTPUT_SHIFT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  fir_decimate_by_five_check #(
    .DECIMATION  (DECIMATION),
    .OUTPUT_SHIFT(OUTPUT_SHIFT)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .sample_count_o(sample_count),
    .word_count_o  (word_count),
    .wrap_count_o  (wrap_count)
  );

  task automatic send_sample(input logic [15:0] sample);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // A run of 87 samples whose signs follow the coefficients drives the sum
  // toward its largest magnitude, well past what 16 bits can hold.
  task automatic send_tap_burst();
    logic [15:0] hi;
    logic [15:0] lo;
    bit          flip;
    hi   = ($urandom_range(0, 3) != 0) ? 16'h7fff : 16'($urandom_range(1, 32767));
    lo   = (hi == 16'h7fff) ? 16'h8000 : -hi;
    flip = $urandom_range(0, 1);
    for (int i = 0; i < fdf_pkg::TAP_COUNT; i++) begin
      send_sample(((fdf_pkg::TAPS[i] < 0) ^ flip) ? lo : hi);
    end
  endtask

  initial begin
    logic [15:0] directed [$];
    int          len;
    bit          pressured;
    pressured = 1'b0;
    directed = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa};
    repeat (5) directed.push_back(16'h7fff);
    repeat (5) directed.push_back(16'h8000);
    repeat (3) begin
      directed.push_back(16'h7fff);
      directed.push_back(16'h8000);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_sample(directed[i]);
    wait_for_drain();
    while (sent < SAMPLE_TOTAL) begin
      steady = ($urandom_range(0, 3) == 0);
      if (!pressured && sent > SAMPLE_TOTAL / 2) begin
        wait_for_drain();
        pressured = 1'b1;
      end
      len = $urandom_range(5, 40);
      case ($urandom_range(0, 4))
        0, 1: send_tap_burst();
        2: repeat (len) send_sample(16'($urandom));
        3: repeat (len) send_sample(16'($urandom_range(0, 31) - 16));
        default: repeat (len) begin
          case ($urandom_range(0, 3))
            0: send_sample(16'h7fff);
            1: send_sample(16'h8000);
            2: send_sample(16'h0000);
            default: send_sample(16'hffff);
          endcase
        end
      endcase
    end
    steady = 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d samples: directed extremes, noise, small values and",
             sample_count);
    $display("coefficient-matched full-scale runs; %0d filtered words, %0d wrapped.",
             word_count, wrap_count);
    if (fail_count == 0 && pending == 0) begin
      $display("fir_decimate_by_five_test passed");
    end else begin
      $display("fir_decimate_by_five_test failed");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (stall - 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("fir_decimate_by_five_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

>>> fir_decimate_by_five.f
src/fdf_pkg.sv
src/fdf_ram.sv
src/fir_decimate_by_five.sv
test/fir_decimate_by_five_check.sv
test/fir_decimate_by_five_test.sv
